// ----- sv/spq_pkg.sv -----
// shared types and codes for the stable minimum priority queue
// no dependencies; compiled first

package spq_pkg;

	// operation codes carried in the func field of an input word
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// per-cycle command broadcast from the control to every cell
	typedef struct packed {
		logic ins;  // insert the new entry, shifting the tail end right
		logic rem;  // remove the head, shifting every cell left
	} spq_ctrl_t;

endpackage

// ----- sv/spq_in_if.sv -----
// input channel of the priority queue: valid/ready plus one operation word
// no dependencies

interface spq_in_if #(
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 8
);
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [PAYLOAD_BITS-1:0]  item_payload;
	logic [PRIORITY_BITS-1:0] item_priority;

	modport source (output valid, func, item_payload, item_priority, input ready);
	modport sink   (input valid, func, item_payload, item_priority, output ready);
endinterface

// ----- sv/spq_out_if.sv -----
// output channel of the priority queue: valid/ready plus one result word
// no dependencies

interface spq_out_if #(
	parameter int PAYLOAD_BITS = 32,
	parameter int COUNT_BITS   = 5
);
	logic                    valid;
	logic                    ready;
	logic [PAYLOAD_BITS-1:0] removed_payload;
	logic                    removed_valid;
	logic [PAYLOAD_BITS-1:0] head_payload;
	logic [PAYLOAD_BITS-1:0] tail_payload;
	logic [COUNT_BITS-1:0]   entry_count;
	logic                    is_empty;
	logic                    dropped;

	modport source (output valid, removed_payload, removed_valid, head_payload,
		tail_payload, entry_count, is_empty, dropped, input ready);
	modport sink   (input valid, removed_payload, removed_valid, head_payload,
		tail_payload, entry_count, is_empty, dropped, output ready);
endinterface

// ----- sv/spq_cell.sv -----
// one slot of the sorted queue: holds an entry and trades it with its neighbors
// depends on spq_pkg

module spq_cell import spq_pkg::*; #(
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                     clk,
	input  spq_ctrl_t                ctrl,
	input  logic [PAYLOAD_BITS-1:0]  new_payload,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic                     occupied,
	input  logic                     left_keep,
	input  logic [PAYLOAD_BITS-1:0]  left_payload,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic [PAYLOAD_BITS-1:0]  right_payload,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	output logic [PAYLOAD_BITS-1:0]  payload,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic                     keep
);

	logic [PAYLOAD_BITS-1:0]  payload_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// entry stays put on insert when it is served no later than the new one
	assign keep = occupied && (prio_q <= new_prio);

	always_ff @(posedge clk) begin
		if (ctrl.ins && !keep) begin
			if (left_keep) begin
				payload_q <= new_payload;
				prio_q    <= new_prio;
			end else begin
				payload_q <= left_payload;
				prio_q    <= left_prio;
			end
		end else if (ctrl.rem) begin
			payload_q <= right_payload;
			prio_q    <= right_prio;
		end
	end

	assign payload = payload_q;
	assign prio    = prio_q;

endmodule

// ----- sv/stable_min_priority_queue.sv -----
// top level of the stable minimum priority queue: control, count, tail and result register
// depends on spq_pkg, spq_in_if, spq_out_if and spq_cell

// Bounded priority queue built as a row of DEPTH cells kept in service order,
// cell 0 holding the head. One word is taken per clock while the input is
// ready: an enqueue (func 0) or a dequeue (func 1). Every cell compares its
// priority with the incoming one at the same time, so an insert lands after
// all entries of lower or equal priority, which keeps equal priorities in
// arrival order; a dequeue shifts the whole row one cell toward the head. The
// result word is registered and appears in the cycle after the input is
// taken; the input stays ready while that register is empty or being drained,
// so the queue sustains one word per cycle. An enqueue into a full queue is
// discarded and flagged with dropped; a dequeue of an empty queue returns
// zeros with removed_valid low. head, tail and count reflect the queue after
// the operation and read as zero when it is empty. Slot contents are not
// reset; only the occupancy count and the result valid flag are, so the queue
// is usable right after arst_n rises.

module stable_min_priority_queue import spq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);

	localparam int CNT_BITS = $clog2(DEPTH + 1);

	// cell row
	logic [PAYLOAD_BITS-1:0]  cell_payload [DEPTH];
	logic [PRIORITY_BITS-1:0] cell_prio    [DEPTH];
	logic [DEPTH-1:0]         cell_keep;
	logic [DEPTH-1:0]         cell_occ;

	// control state
	logic [CNT_BITS-1:0]      count_q;
	logic [PAYLOAD_BITS-1:0]  tail_payload_q;
	logic [PRIORITY_BITS-1:0] tail_prio_q;

	// result register
	logic                    out_valid_q;
	logic [PAYLOAD_BITS-1:0] removed_payload_q;
	logic                    removed_valid_q;
	logic [PAYLOAD_BITS-1:0] head_payload_q;
	logic [PAYLOAD_BITS-1:0] tail_out_q;
	logic [CNT_BITS-1:0]     count_out_q;
	logic                    is_empty_q;
	logic                    dropped_q;

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    enq_do;
	logic                    deq_do;
	logic                    at_end;
	spq_ctrl_t               ctrl;
	logic [CNT_BITS-1:0]     count_d;
	logic [PAYLOAD_BITS-1:0] head_d;
	logic [PAYLOAD_BITS-1:0] tail_d;

	// input side is free whenever the result register can take a new word
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign full   = (count_q == CNT_BITS'(DEPTH));
	assign empty  = (count_q == '0);
	assign enq_do = accept && (in_ch.func == FUNC_ENQ) && !full;
	assign deq_do = accept && (in_ch.func == FUNC_DEQ) && !empty;

	assign ctrl.ins = enq_do;
	assign ctrl.rem = deq_do;

	// the tail holds the largest priority, so one compare tells whether
	// the new entry goes to the back
	assign at_end = empty || (tail_prio_q <= in_ch.item_priority);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                     lkeep;
			logic [PAYLOAD_BITS-1:0]  lpay;
			logic [PRIORITY_BITS-1:0] lprio;
			logic [PAYLOAD_BITS-1:0]  rpay;
			logic [PRIORITY_BITS-1:0] rprio;

			assign cell_occ[gi] = (count_q > CNT_BITS'(gi));

			if (gi == 0) begin : g_first
				// head cell sees a virtual neighbor that always stays ahead
				assign lkeep = 1'b1;
				assign lpay  = '0;
				assign lprio = '0;
			end else begin : g_mid
				assign lkeep = cell_keep[gi-1];
				assign lpay  = cell_payload[gi-1];
				assign lprio = cell_prio[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign rpay  = '0;
				assign rprio = '0;
			end else begin : g_inner
				assign rpay  = cell_payload[gi+1];
				assign rprio = cell_prio[gi+1];
			end

			spq_cell #(
				.PAYLOAD_BITS  (PAYLOAD_BITS),
				.PRIORITY_BITS (PRIORITY_BITS)
			) u_cell (
				.clk           (clk),
				.ctrl          (ctrl),
				.new_payload   (in_ch.item_payload),
				.new_prio      (in_ch.item_priority),
				.occupied      (cell_occ[gi]),
				.left_keep     (lkeep),
				.left_payload  (lpay),
				.left_prio     (lprio),
				.right_payload (rpay),
				.right_prio    (rprio),
				.payload       (cell_payload[gi]),
				.prio          (cell_prio[gi]),
				.keep          (cell_keep[gi])
			);
		end
	endgenerate

	// queue state after this word
	always_comb begin
		count_d = count_q;
		head_d  = cell_payload[0];
		tail_d  = tail_payload_q;
		if (enq_do) begin
			count_d = count_q + 1'b1;
			if (!cell_keep[0]) begin
				head_d = in_ch.item_payload;
			end
			if (at_end) begin
				tail_d = in_ch.item_payload;
			end
		end else if (deq_do) begin
			count_d = count_q - 1'b1;
			head_d  = cell_payload[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (enq_do && at_end) begin
			tail_payload_q <= in_ch.item_payload;
			tail_prio_q    <= in_ch.item_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word, zeros stand in for head and tail of an empty queue
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_payload_q <= deq_do ? cell_payload[0] : '0;
			removed_valid_q   <= deq_do;
			head_payload_q    <= (count_d == '0) ? '0 : head_d;
			tail_out_q        <= (count_d == '0) ? '0 : tail_d;
			count_out_q       <= count_d;
			is_empty_q        <= (count_d == '0);
			dropped_q         <= (in_ch.func == FUNC_ENQ) && full;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.removed_payload = removed_payload_q;
	assign out_ch.removed_valid   = removed_valid_q;
	assign out_ch.head_payload    = head_payload_q;
	assign out_ch.tail_payload    = tail_out_q;
	assign out_ch.entry_count     = count_out_q;
	assign out_ch.is_empty        = is_empty_q;
	assign out_ch.dropped         = dropped_q;

	// occupancy never runs past the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("occupancy above depth");

	// a drop is only reported for a full queue
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q) |-> (count_out_q == CNT_BITS'(DEPTH)))
		else $error("drop reported on a queue that was not full");

	// a real removal lowers the count by one
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		deq_do |=> (count_q == $past(count_q) - 1'b1))
		else $error("dequeue did not lower occupancy");

	// a word is never both a removal and a drop
	a_rem_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(removed_valid_q && dropped_q))
		else $error("removal and drop in one result");

	// registered count matches the live occupancy once the word is out
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_out_q == count_q))
		else $error("result count out of step with occupancy");

endmodule

// ----- bench/spq_order_check.sv -----
`timescale 1ns / 1ps
// result checker for the stable minimum priority queue: keeps its own sorted copy of the queue
// depends on spq_pkg, spq_in_if and spq_out_if; instantiated by tb beside the block

module spq_order_check import spq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 8,
	parameter int COUNT_BITS    = 5
) (
	input  logic clk,
	input  logic arst_n,
	spq_in_if    in_ch,
	spq_out_if   out_ch,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output int   refusals
);

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] removed_payload;
		logic                    removed_valid;
		logic [PAYLOAD_BITS-1:0] head_payload;
		logic [PAYLOAD_BITS-1:0] tail_payload;
		logic [COUNT_BITS-1:0]   entry_count;
		logic                    is_empty;
		logic                    dropped;
	} spq_result_t;

	// entries in service order, index 0 is the head
	logic [PAYLOAD_BITS-1:0]  slot_pay [DEPTH];
	logic [PRIORITY_BITS-1:0] slot_pri [DEPTH];
	int                       held;

	spq_result_t due_results [$];
	spq_result_t got, want;

	// apply one operation to the sorted copy and return the word it should produce
	function automatic spq_result_t serve_op(input logic f, input logic [PAYLOAD_BITS-1:0] pay,
		input logic [PRIORITY_BITS-1:0] pri);
		spq_result_t r;
		int          pos;
		r = '0;
		if (f == FUNC_ENQ) begin
			if (held >= DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				// land after every entry of lower or equal priority
				pos = 0;
				while (pos < held && slot_pri[pos] <= pri)
					pos++;
				for (int i = held; i > pos; i--) begin
					slot_pay[i] = slot_pay[i-1];
					slot_pri[i] = slot_pri[i-1];
				end
				slot_pay[pos] = pay;
				slot_pri[pos] = pri;
				held++;
			end
		end else if (held > 0) begin
			r.removed_payload = slot_pay[0];
			r.removed_valid   = 1'b1;
			for (int i = 1; i < held; i++) begin
				slot_pay[i-1] = slot_pay[i];
				slot_pri[i-1] = slot_pri[i];
			end
			held--;
		end
		if (held > 0) begin
			r.head_payload = slot_pay[0];
			r.tail_payload = slot_pay[held-1];
		end else begin
			r.is_empty = 1'b1;
		end
		r.entry_count = held[COUNT_BITS-1:0];
		return r;
	endfunction

	function automatic string show(input spq_result_t r);
		return $sformatf("removed=%h/%b head=%h tail=%h count=%0d empty=%b dropped=%b",
			r.removed_payload, r.removed_valid, r.head_payload, r.tail_payload,
			r.entry_count, r.is_empty, r.dropped);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			due_results.delete();
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
			refusals     = 0;
		end else begin
			// a word leaving now belongs to an earlier input, so compare before predicting
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.removed_payload, out_ch.removed_valid, out_ch.head_payload,
					out_ch.tail_payload, out_ch.entry_count, out_ch.is_empty, out_ch.dropped};
				results_seen++;
				if (got.dropped)
					refusals++;
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result word: %s", $time, show(got));
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t mismatch\n  expected %s\n  actual   %s",
							$time, show(want), show(got));
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				due_results.push_back(serve_op(in_ch.func, in_ch.item_payload, in_ch.item_priority));
			pending = due_results.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// top of the priority queue bench: clock, reset, word stimulus, receiver pacing and verdict
// depends on spq_pkg, spq_in_if, spq_out_if, stable_min_priority_queue and spq_order_check

module tb import spq_pkg::*; ;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_BITS  = 32;
	localparam int PRIORITY_BITS = 8;
	localparam int COUNT_BITS    = 5;
	localparam int HALF_PERIOD   = 6;
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run

	logic clk = 1'b0;
	logic arst_n;

	// pacing knobs, in percent of cycles spent idle
	int src_idle  = 0;
	int sink_idle = 0;

	// receiver hold request from the stimulus; the receiver owns the countdown
	logic hold_go = 1'b0;
	int   hold_left = 0;
	logic hold_used = 1'b0;

	int words_sent = 0;
	int cycles = 0;

	int fails, in_flight, seen, refused;

	spq_in_if  #(.PAYLOAD_BITS(PAYLOAD_BITS), .PRIORITY_BITS(PRIORITY_BITS)) in_ch ();
	spq_out_if #(.PAYLOAD_BITS(PAYLOAD_BITS), .COUNT_BITS(COUNT_BITS))       out_ch ();

	stable_min_priority_queue #(
		.DEPTH(DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.PRIORITY_BITS(PRIORITY_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	spq_order_check #(
		.DEPTH(DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS),
		.PRIORITY_BITS(PRIORITY_BITS),
		.COUNT_BITS(COUNT_BITS)
	) order_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fails),
		.pending(in_flight),
		.results_seen(seen),
		.refusals(refused)
	);

	// 12 ns clock
	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycles, in_flight);
			$display("[stable_min_priority_queue] ERROR");
			$finish;
		end
	end

	// receiver: random ready at the falling edge, or a long hold-off once requested
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (hold_go && !hold_used) begin
				// start of the long hold; the result register fills and input backs up
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// offer one word, called at a falling edge; returns at the falling edge after acceptance
	// valid is left high so back-to-back words need no extra assignment
	task automatic send_word(input logic f, input logic [PAYLOAD_BITS-1:0] pay,
		input logic [PRIORITY_BITS-1:0] pri);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid = 1'b0;
			in_ch.func          = logic'($urandom_range(1));
			in_ch.item_payload  = $urandom;
			in_ch.item_priority = PRIORITY_BITS'($urandom);
			@(negedge clk);
		end
		in_ch.valid         = 1'b1;
		in_ch.func          = f;
		in_ch.item_payload  = pay;
		in_ch.item_priority = pri;
		do
			@(posedge clk);
		while (!in_ch.ready);
		words_sent++;
		@(negedge clk);
	endtask

	// random traffic in bursts: fill-heavy bursts reach the full queue and its refusals,
	// drain-heavy ones reach empty dequeues, narrow priority windows force many ties
	task automatic run_bursts(input int n_words);
		int                       left, burst, enq_pct, pri_mode, pri_lo;
		logic                     f;
		logic [PAYLOAD_BITS-1:0]  pay;
		logic [PRIORITY_BITS-1:0] pri;
		left = n_words;
		while (left > 0) begin
			case ($urandom_range(3))
				0:       enq_pct = 85;
				1:       enq_pct = 20;
				default: enq_pct = 55;
			endcase
			pri_mode = $urandom_range(2);
			pri_lo   = $urandom_range(252);
			burst    = 8 + $urandom_range(24);
			if (burst > left)
				burst = left;
			repeat (burst) begin
				f = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				case ($urandom_range(15))
					0:       pay = '0;
					1:       pay = '1;
					default: pay = $urandom;
				endcase
				case (pri_mode)
					0:       pri = PRIORITY_BITS'(pri_lo + $urandom_range(3));
					1:       pri = PRIORITY_BITS'($urandom);
					default: pri = $urandom_range(1) ? '1 : '0;
				endcase
				send_word(f, pay, pri);
				left--;
			end
		end
	endtask

	task automatic drain_wait();
		while (in_flight != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [PRIORITY_BITS-1:0] fill_pri [16];
		fill_pri = '{8'd0, 8'd255, 8'd7, 8'd7, 8'd7, 8'd0, 8'd128, 8'd255,
			8'd1, 8'd7, 8'd0, 8'd254, 8'd7, 8'd255, 8'd3, 8'd0};

		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.func          = FUNC_ENQ;
		in_ch.item_payload  = '0;
		in_ch.item_priority = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, no idling: dequeue of an empty queue first
		send_word(FUNC_DEQ, '1, '1);
		// fill to capacity with extreme payloads and priorities and runs of equal priority,
		// so arrival order among ties shows up in head and tail
		for (int k = 0; k < DEPTH; k++)
			send_word(FUNC_ENQ, (k == 1) ? '1 : ((k == 0) ? '0 : 32'h5a00_0000 + k), fill_pri[k]);
		// enqueues into the full queue are refused
		send_word(FUNC_ENQ, '1, '0);
		send_word(FUNC_ENQ, '0, '1);
		// a few dequeues pull the zero-priority entries in arrival order
		send_word(FUNC_DEQ, 32'h0bad_0001, 8'h55);
		send_word(FUNC_DEQ, '0, '0);
		send_word(FUNC_DEQ, '1, '1);

		// pressure: receiver holds off while words keep coming, input must stall
		hold_go = 1'b1;
		repeat (40)
			send_word(FUNC_ENQ, $urandom, PRIORITY_BITS'($urandom));
		// sender pauses until every owed word has come back
		in_ch.valid = 1'b0;
		drain_wait();

		// busy sender, slow receiver
		src_idle  = 17;
		sink_idle = 76;
		run_bursts(610);
		// slow sender, busy receiver
		src_idle  = 76;
		sink_idle = 17;
		run_bursts(610);
		// full rate both sides
		src_idle  = 0;
		sink_idle = 0;
		run_bursts(620);

		in_ch.valid = 1'b0;
		drain_wait();
		repeat (8) @(posedge clk);

		$display("sent %0d queue operations, checked %0d result words", words_sent, seen);
		$display("enqueues refused on a full queue: %0d, long receiver hold-off of %0d cycles",
			refused, HOLD_CYCLES);
		if (fails == 0 && in_flight == 0) begin
			$display("[stable_min_priority_queue] OK");
		end else begin
			$display("[stable_min_priority_queue] ERROR");
		end
		$finish;
	end

endmodule
